@@ design/lpf_pkg.sv @@
// Package for the longest palindrome finder.
// Sizes, derived widths and the sequencer state type; no dependencies.
`default_nettype none
package lpf_pkg;
	localparam int MAX_LEN  = 1024;
	localparam int SEP_LEN  = 2 * MAX_LEN + 1;
	localparam int TEXT_AW  = $clog2(MAX_LEN);
	localparam int CNT_W    = $clog2(MAX_LEN + 1);
	localparam int POS_W    = $clog2(SEP_LEN + 1);
	localparam int EXT_W    = POS_W + 1;
	localparam int START_W  = 10;
	localparam int LEN_W    = 11;

	typedef enum logic [2:0] {
		S_LOAD,
		S_START,
		S_MIRROR,
		S_EXPAND,
		S_CMP,
		S_WRITE,
		S_RESULT
	} state_t;
endpackage
`default_nettype wire

@@ design/lpf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ design/longest_palindrome_finder.sv @@
// Longest palindromic substring finder (Manacher over a separated string).
// Load: one byte per cycle while in_ready is high (S_LOAD only). After the last beat the search runs:
// per separated position a start step, a mirror read when inside the right edge, expand steps (one per
// separator step, a read and a compare per byte pair, one for a probe stopped at a string end) and a write.
// Result waits in an output register; a new string loads meanwhile. Reset clears
// control state; text and radius RAMs are not cleared (only written entries are read).
// Depends on lpf_pkg and lpf_ram.
`default_nettype none
module longest_palindrome_finder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    char_in,
	input  wire logic                          last_char,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [lpf_pkg::START_W-1:0]        start_index,
	output logic [lpf_pkg::LEN_W-1:0]          pal_length,
	output logic                               overflow
);
	localparam int POS_W   = lpf_pkg::POS_W;
	localparam int EXT_W   = lpf_pkg::EXT_W;
	localparam int CNT_W   = lpf_pkg::CNT_W;
	localparam int TEXT_AW = lpf_pkg::TEXT_AW;

	lpf_pkg::state_t state_q, state_d;

	// control and search registers
	logic [CNT_W-1:0] cnt_q;        // bytes stored
	logic             ovf_q;        // byte dropped in this string
	logic [POS_W-1:0] i_q;          // current separated position
	logic [CNT_W-1:0] r_q;          // radius under construction
	logic [POS_W-1:0] ctr_q;        // center reaching furthest right
	logic [POS_W-1:0] redge_q;      // its right edge
	logic [CNT_W-1:0] best_len_q;
	logic [POS_W-1:0] best_ctr_q;

	// result register
	logic                        out_valid_q;
	logic [lpf_pkg::START_W-1:0] start_q;
	logic [lpf_pkg::LEN_W-1:0]   len_q;
	logic                        out_ovf_q;

	// memory ports
	logic             text_we;
	logic             text_re;
	logic [7:0]       text_a_rdata, text_b_rdata;
	logic             rad_re, rad_we;
	logic [POS_W-1:0] rad_raddr;
	logic [CNT_W-1:0] rad_rdata;

	// datapath terms
	logic             in_beat, out_beat;
	logic [POS_W-1:0] m_w;          // length of separated string: 2n+1
	logic [EXT_W-1:0] a_w, b_w;     // right and left probe positions
	logic             can_exp;
	logic [POS_W-1:0] mirror_w, span_w;
	logic             i_lt_re;
	logic             more_pos;
	logic             slot_free;
	logic [POS_W-1:0] diff_w;

	assign in_beat   = in_valid && in_ready;
	assign out_beat  = out_valid_q && out_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign m_w      = {cnt_q, 1'b1};
	assign a_w      = EXT_W'(i_q) + EXT_W'(r_q) + EXT_W'(1);
	assign b_w      = EXT_W'(i_q) - EXT_W'(r_q) - EXT_W'(1);
	// probe stays inside the separated string on both sides
	assign can_exp  = (a_w < EXT_W'(m_w)) && (EXT_W'(r_q) < EXT_W'(i_q));
	assign mirror_w = POS_W'(EXT_W'({ctr_q, 1'b0}) - EXT_W'(i_q));
	assign span_w   = redge_q - i_q;
	assign i_lt_re  = i_q < redge_q;
	assign more_pos = (EXT_W'(i_q) + EXT_W'(2)) < EXT_W'(m_w);
	assign diff_w   = best_ctr_q - POS_W'(best_len_q);

	// text is stored twice so both probe bytes are read together
	assign text_we = in_beat && (cnt_q < CNT_W'(lpf_pkg::MAX_LEN));

	lpf_ram #(.WIDTH(8), .DEPTH(lpf_pkg::MAX_LEN)) u_text_a (
		.clk   (clk),
		.we    (text_we),
		.waddr (cnt_q[TEXT_AW-1:0]),
		.wdata (char_in),
		.re    (text_re),
		.raddr (a_w[TEXT_AW:1]),
		.rdata (text_a_rdata)
	);

	lpf_ram #(.WIDTH(8), .DEPTH(lpf_pkg::MAX_LEN)) u_text_b (
		.clk   (clk),
		.we    (text_we),
		.waddr (cnt_q[TEXT_AW-1:0]),
		.wdata (char_in),
		.re    (text_re),
		.raddr (b_w[TEXT_AW:1]),
		.rdata (text_b_rdata)
	);

	lpf_ram #(.WIDTH(CNT_W), .DEPTH(lpf_pkg::SEP_LEN)) u_radius (
		.clk   (clk),
		.we    (rad_we),
		.waddr (i_q),
		.wdata (r_q),
		.re    (rad_re),
		.raddr (rad_raddr),
		.rdata (rad_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpf_pkg::S_LOAD: begin
				if (in_beat && last_char) state_d = lpf_pkg::S_START;
			end
			lpf_pkg::S_START: begin
				state_d = i_lt_re ? lpf_pkg::S_MIRROR : lpf_pkg::S_EXPAND;
			end
			lpf_pkg::S_MIRROR: state_d = lpf_pkg::S_EXPAND;
			lpf_pkg::S_EXPAND: begin
				if (!can_exp) state_d = lpf_pkg::S_WRITE;
				else if (a_w[0]) state_d = lpf_pkg::S_CMP;
			end
			lpf_pkg::S_CMP: begin
				state_d = (text_a_rdata == text_b_rdata) ? lpf_pkg::S_EXPAND
				                                         : lpf_pkg::S_WRITE;
			end
			lpf_pkg::S_WRITE: begin
				state_d = more_pos ? lpf_pkg::S_START : lpf_pkg::S_RESULT;
			end
			lpf_pkg::S_RESULT: begin
				if (slot_free) state_d = lpf_pkg::S_LOAD;
			end
			default: state_d = lpf_pkg::S_LOAD;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready  = 1'b0;
		rad_re    = 1'b0;
		rad_we    = 1'b0;
		text_re   = 1'b0;
		rad_raddr = mirror_w;
		case (state_q)
			lpf_pkg::S_LOAD:   in_ready = 1'b1;
			lpf_pkg::S_START:  rad_re = i_lt_re;
			lpf_pkg::S_EXPAND: text_re = can_exp && a_w[0];
			lpf_pkg::S_WRITE:  rad_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpf_pkg::S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			r_q         <= '0;
			ctr_q       <= '0;
			redge_q     <= '0;
			best_len_q  <= '0;
			best_ctr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a result loaded on the same edge keeps the slot full
			if (out_beat && !(state_q == lpf_pkg::S_RESULT && slot_free))
				out_valid_q <= 1'b0;
			case (state_q)
				lpf_pkg::S_LOAD: begin
					if (in_beat) begin
						if (text_we) cnt_q <= cnt_q + CNT_W'(1);
						else         ovf_q <= 1'b1;
						if (last_char) begin
							i_q        <= POS_W'(1);
							ctr_q      <= '0;
							redge_q    <= '0;
							best_len_q <= '0;
							best_ctr_q <= '0;
						end
					end
				end
				lpf_pkg::S_START: r_q <= '0;
				lpf_pkg::S_MIRROR: begin
					// radius seeded from the mirror, clipped at the right edge
					r_q <= (POS_W'(rad_rdata) > span_w) ? CNT_W'(span_w) : rad_rdata;
				end
				lpf_pkg::S_EXPAND: begin
					// separator pair always matches
					if (can_exp && !a_w[0]) r_q <= r_q + CNT_W'(1);
				end
				lpf_pkg::S_CMP: begin
					if (text_a_rdata == text_b_rdata) r_q <= r_q + CNT_W'(1);
				end
				lpf_pkg::S_WRITE: begin
					if ((EXT_W'(i_q) + EXT_W'(r_q)) > EXT_W'(redge_q)) begin
						ctr_q   <= i_q;
						redge_q <= POS_W'(EXT_W'(i_q) + EXT_W'(r_q));
					end
					if (r_q > best_len_q) begin
						best_len_q <= r_q;
						best_ctr_q <= i_q;
					end
					i_q <= i_q + POS_W'(1);
				end
				lpf_pkg::S_RESULT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						ctr_q       <= '0;
						redge_q     <= '0;
						best_len_q  <= '0;
						best_ctr_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result payload, loaded when the output slot frees up
	always_ff @(posedge clk) begin
		if (state_q == lpf_pkg::S_RESULT && slot_free) begin
			start_q   <= diff_w[lpf_pkg::START_W:1];
			len_q     <= lpf_pkg::LEN_W'(best_len_q);
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign start_index = start_q;
	assign pal_length  = len_q;
	assign overflow    = out_ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(lpf_pkg::MAX_LEN))
		else $error("byte count beyond capacity");

	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		POS_W'(best_len_q) <= best_ctr_q)
		else $error("best radius exceeds its center");

	a_redge_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lpf_pkg::S_LOAD && $past(state_q) != lpf_pkg::S_LOAD)
		|-> redge_q >= $past(redge_q))
		else $error("right edge moved left during search");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpf_pkg::S_RESULT && slot_free) |=> out_valid && cnt_q == '0)
		else $error("result not presented or count not cleared");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lpf_pkg::S_LOAD) |-> !text_we)
		else $error("text written during search");
endmodule
`default_nettype wire
